>>> rtl/core/ntx_pkg.sv
// Package for the nth-token extractor: character codes, scan modes, status codes,
// register indexes and the result record.
// No dependencies; every other file of the block imports it.
`timescale 1ns / 1ps

package ntx_pkg;

	// Saturation limit of the bracket nesting counter.
	localparam logic [7:0] MAX_NEST = 8'd255;

	// Character codes that steer the scanner.
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;

	typedef enum logic [2:0] {
		MODE_BETWEEN,
		MODE_SKIP_PLAIN,
		MODE_SKIP_QUOTE,
		MODE_SKIP_BRACKET,
		MODE_COPY_PLAIN,
		MODE_COPY_QUOTE,
		MODE_COPY_BRACKET
	} scan_mode_t;

	typedef enum logic [1:0] {
		STATUS_RUN,
		STATUS_OK,
		STATUS_NOT_FOUND,
		STATUS_TRUNC
	} status_t;

	typedef enum logic {
		REG_TOKEN_INDEX = 1'b0,
		REG_MAX_LEN     = 1'b1
	} reg_index_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       has_byte;
		status_t    status;
		logic       last;
	} result_t;

endpackage

>>> rtl/core/ntx_if.sv
// Stream interfaces of the nth-token extractor: the character channel and the
// token channel, each with valid/ready handshake. Depends on ntx_pkg.
`timescale 1ns / 1ps

interface ntx_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       end_of_line;

	modport source (output valid, output in_byte, output end_of_line, input ready);
	modport sink (input valid, input in_byte, input end_of_line, output ready);
endinterface

interface ntx_token_if
	import ntx_pkg::*;
;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       has_byte;
	status_t    status;
	logic       last;

	modport source (output valid, output out_byte, output has_byte, output status,
		output last, input ready);
	modport sink (input valid, input out_byte, input has_byte, input status,
		input last, output ready);
endinterface

>>> rtl/core/nth_token_extractor.sv
// Top level of the nth-token extractor: input register, scanner logic and result register.
// Depends on ntx_pkg and the stream interfaces in ntx_if.
// The input register takes each character; the result register takes its result.
// Throughput: one character per cycle while the input stage does not stall.
// The input stage stalls only while a result waits in the result register.
// Reset (arst_n low, asynchronous) clears the scan state, empties both stages and loads
// token_index with 1 and max_len with 64.
`timescale 1ns / 1ps

module nth_token_extractor
	import ntx_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	ntx_char_if.sink         chars,
	ntx_token_if.source      tokens,
	input  logic             wr_en,
	input  reg_index_t       wr_index,
	input  logic [7:0]       wr_data
);

	// Configuration registers.
	logic [7:0] token_index_q;
	logic [7:0] max_len_q;

	// Scan state.
	scan_mode_t mode_q, mode_d;
	logic [7:0] tokens_seen_q, tokens_seen_d;
	logic       close_single_q, close_single_d;
	logic [7:0] nest_depth_q, nest_depth_d;
	logic [7:0] bytes_copied_q, bytes_copied_d;
	logic       finished_q, finished_d;

	// Input stage and result stage.
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eol_s1;
	logic       valid_s2;
	result_t    res_s2;

	logic       is_ws, is_break, is_quote, is_lparen, is_rparen, is_close_quote;
	logic [7:0] tokens_inc, bytes_inc, depth_open, depth_close;
	logic       trunc, match, copying;
	logic       emit;
	result_t    res;
	logic       out_free, s1_go;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			token_index_q <= 8'd1;
			max_len_q     <= 8'd64;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_TOKEN_INDEX: token_index_q <= wr_data;
				REG_MAX_LEN:     max_len_q     <= wr_data;
				default:         ;
			endcase
		end
	end

	// Character classes of the byte in the input stage.
	assign is_ws          = (byte_s1 == CH_SPACE) || (byte_s1 == CH_TAB);
	assign is_break       = (byte_s1 == CH_LF) || (byte_s1 == CH_CR);
	assign is_quote       = (byte_s1 == CH_DQUOTE) || (byte_s1 == CH_SQUOTE);
	assign is_lparen      = (byte_s1 == CH_LPAREN);
	assign is_rparen      = (byte_s1 == CH_RPAREN);
	assign is_close_quote = close_single_q ? (byte_s1 == CH_SQUOTE) : (byte_s1 == CH_DQUOTE);

	// Saturating counters and the truncation check.
	assign tokens_inc  = (tokens_seen_q == 8'hFF) ? tokens_seen_q : tokens_seen_q + 8'd1;
	assign bytes_inc   = (bytes_copied_q == 8'hFF) ? bytes_copied_q : bytes_copied_q + 8'd1;
	assign depth_open  = (nest_depth_q < MAX_NEST) ? nest_depth_q + 8'd1 : nest_depth_q;
	assign depth_close = (nest_depth_q != 8'd0) ? nest_depth_q - 8'd1 : 8'd0;
	assign trunc       = (bytes_inc >= max_len_q);
	assign match       = (token_index_q != 8'd0) && (tokens_inc == token_index_q);
	assign copying     = (mode_q == MODE_COPY_PLAIN) || (mode_q == MODE_COPY_QUOTE) ||
		(mode_q == MODE_COPY_BRACKET);

	// Scanner: next state and the result of the character in the input stage.
	always_comb begin
		mode_d         = mode_q;
		tokens_seen_d  = tokens_seen_q;
		close_single_d = close_single_q;
		nest_depth_d   = nest_depth_q;
		bytes_copied_d = bytes_copied_q;
		finished_d     = finished_q;
		emit           = 1'b0;
		res.out_byte   = 8'd0;
		res.has_byte   = 1'b0;
		res.status     = STATUS_RUN;
		res.last       = 1'b0;

		if (eol_s1) begin
			// End of line closes the extraction and restarts the scanner.
			emit           = !finished_q;
			res.status     = copying ? STATUS_OK : STATUS_NOT_FOUND;
			mode_d         = MODE_BETWEEN;
			tokens_seen_d  = 8'd0;
			close_single_d = 1'b0;
			nest_depth_d   = 8'd0;
			bytes_copied_d = 8'd0;
		end else if (!finished_q) begin
			unique case (mode_q)
				MODE_BETWEEN: begin
					if (!is_ws && !is_break) begin
						tokens_seen_d = tokens_inc;
						if (is_quote) begin
							close_single_d = (byte_s1 == CH_SQUOTE);
							mode_d = match ? MODE_COPY_QUOTE : MODE_SKIP_QUOTE;
						end else if (is_lparen) begin
							nest_depth_d = 8'd1;
							mode_d = match ? MODE_COPY_BRACKET : MODE_SKIP_BRACKET;
						end else begin
							mode_d = match ? MODE_COPY_PLAIN : MODE_SKIP_PLAIN;
						end
						// The opening byte of a plain or bracket token is copied at once.
						if (match && !is_quote) begin
							emit           = 1'b1;
							res.has_byte   = 1'b1;
							res.out_byte   = byte_s1;
							bytes_copied_d = bytes_inc;
							res.status     = trunc ? STATUS_TRUNC : STATUS_RUN;
						end
					end
				end
				MODE_SKIP_PLAIN: begin
					if (is_ws) begin
						mode_d = MODE_BETWEEN;
					end
				end
				MODE_SKIP_QUOTE: begin
					if (is_close_quote) begin
						mode_d = MODE_BETWEEN;
					end
				end
				MODE_SKIP_BRACKET: begin
					if (is_rparen) begin
						nest_depth_d = depth_close;
						if (depth_close == 8'd0) begin
							mode_d = MODE_BETWEEN;
						end
					end else if (is_lparen) begin
						nest_depth_d = depth_open;
					end
				end
				MODE_COPY_PLAIN, MODE_COPY_QUOTE: begin
					emit = 1'b1;
					if ((mode_q == MODE_COPY_PLAIN) ? is_ws : is_close_quote) begin
						res.status = STATUS_OK;
					end else begin
						res.has_byte   = 1'b1;
						res.out_byte   = byte_s1;
						bytes_copied_d = bytes_inc;
						res.status     = trunc ? STATUS_TRUNC : STATUS_RUN;
					end
				end
				MODE_COPY_BRACKET: begin
					emit           = 1'b1;
					res.has_byte   = 1'b1;
					res.out_byte   = byte_s1;
					bytes_copied_d = bytes_inc;
					if (is_rparen) begin
						nest_depth_d = depth_close;
					end else if (is_lparen) begin
						nest_depth_d = depth_open;
					end
					// Truncation wins over the closing bracket.
					if (trunc) begin
						res.status = STATUS_TRUNC;
					end else if (nest_depth_d == 8'd0) begin
						res.status = STATUS_OK;
					end
				end
				default: begin
					mode_d = MODE_BETWEEN;
				end
			endcase
			res.last = (res.status != STATUS_RUN);
			if (emit && res.last) begin
				finished_d = 1'b1;
			end
		end

		if (eol_s1) begin
			res.last   = 1'b1;
			finished_d = 1'b0;
		end
	end

	// Handshake: the input stage moves on unless its result finds the result register full.
	assign out_free     = !valid_s2 || tokens.ready;
	assign s1_go        = valid_s1 && (!emit || out_free);
	assign chars.ready  = !valid_s1 || s1_go;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.ready && chars.valid) begin
			byte_s1 <= chars.in_byte;
			eol_s1  <= chars.end_of_line;
		end
	end

	// Scan state update, one character per transfer out of the input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q         <= MODE_BETWEEN;
			tokens_seen_q  <= 8'd0;
			close_single_q <= 1'b0;
			nest_depth_q   <= 8'd0;
			bytes_copied_q <= 8'd0;
			finished_q     <= 1'b0;
		end else if (s1_go) begin
			mode_q         <= mode_d;
			tokens_seen_q  <= tokens_seen_d;
			close_single_q <= close_single_d;
			nest_depth_q   <= nest_depth_d;
			bytes_copied_q <= bytes_copied_d;
			finished_q     <= finished_d;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s1_go && emit) begin
			valid_s2 <= 1'b1;
		end else if (tokens.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && emit) begin
			res_s2 <= res;
		end
	end

	assign tokens.valid    = valid_s2;
	assign tokens.out_byte = res_s2.out_byte;
	assign tokens.has_byte = res_s2.has_byte;
	assign tokens.status   = res_s2.status;
	assign tokens.last     = res_s2.last;

endmodule

>>> rtl/core/ntx_checker.sv
// Port-level checker for the nth-token extractor and the bind that attaches it.
// Depends on ntx_pkg and the top level nth_token_extractor.
`timescale 1ns / 1ps

module ntx_checker
	import ntx_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       has_byte,
	input status_t    status,
	input logic       last
);

	// A result without a token byte carries a zero byte.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !has_byte |-> out_byte == 8'd0)
		else $error("ntx: empty result with nonzero byte");

	// A running result always carries a token byte.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STATUS_RUN |-> has_byte)
		else $error("ntx: running result without byte");

	// The last flag marks exactly the results that end the extraction.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> last == (status != STATUS_RUN))
		else $error("ntx: last flag disagrees with status");

	// A stalled result stays in place until its transfer.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(status)
			&& $stable(last))
		else $error("ntx: stalled result changed");

endmodule

bind nth_token_extractor ntx_checker u_ntx_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (tokens.valid),
	.out_ready (tokens.ready),
	.out_byte  (tokens.out_byte),
	.has_byte  (tokens.has_byte),
	.status    (tokens.status),
	.last      (tokens.last)
);

>>> dv/tb_top.sv
// Testbench for nth_token_extractor: drives lines of characters, predicts the token stream
// and compares every token-channel transfer field by field with the prediction.
// Depends on ntx_pkg, the stream interfaces in ntx_if and the block itself.
`timescale 1ns / 1ps

module tb_top;
	import ntx_pkg::*;

	localparam int RANDOM_ITEMS = 1130;
	localparam int HOLD_CYCLES = 64;
	localparam int SETTLE_CYCLES = 4;
	localparam int DIR_ROWS = 22;
	localparam result_t NO_RESULT = '0;
	localparam logic [7:0] SPECIALS [8] = '{CH_TAB, CH_LF, CH_CR, CH_SPACE,
		CH_DQUOTE, CH_SQUOTE, CH_LPAREN, CH_RPAREN};

	// One row of the directed table; the result is used only where typed is set.
	typedef struct packed {
		logic [7:0] ch;
		logic       eol;
		logic       typed;
		logic       has_res;
		result_t    res;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic wr_en;
	reg_index_t wr_index;
	logic [7:0] wr_data;

	ntx_char_if  chars_bus ();
	ntx_token_if tokens_bus ();

	nth_token_extractor dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.chars    (chars_bus),
		.tokens   (tokens_bus),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	// Scanner state and register copies kept by the token predictor.
	scan_mode_t mode;
	logic [7:0] tok_count;
	logic [7:0] close_char;
	logic [7:0] depth;
	logic [7:0] copied;
	logic       line_done;
	logic [7:0] want_index;
	logic [7:0] len_limit;

	result_t token_due_q [$];
	logic [7:0] line_q [$];
	int mismatch_count = 0;
	int active_items = 0;
	bit send_idle = 1'b1;
	bit recv_idle = 1'b1;
	bit hold_req = 1'b0;

	// Default config after reset: first token, 64-byte length limit.
	dir_row_t dir_table [DIR_ROWS] = '{
		'{CH_LF,     1'b0, 1'b1, 1'b0, NO_RESULT},
		'{CH_CR,     1'b0, 1'b1, 1'b0, NO_RESULT},
		'{CH_SPACE,  1'b0, 1'b1, 1'b0, NO_RESULT},
		'{8'h00,     1'b0, 1'b1, 1'b1, '{8'h00, 1'b1, STATUS_RUN, 1'b0}},
		'{8'hFF,     1'b0, 1'b1, 1'b1, '{8'hFF, 1'b1, STATUS_RUN, 1'b0}},
		'{CH_TAB,    1'b0, 1'b1, 1'b1, '{8'h00, 1'b0, STATUS_OK, 1'b1}},
		'{"x",       1'b0, 1'b1, 1'b0, NO_RESULT},
		'{8'hFF,     1'b1, 1'b1, 1'b0, NO_RESULT},
		'{CH_DQUOTE, 1'b0, 1'b0, 1'b0, NO_RESULT},
		'{"a",       1'b0, 1'b0, 1'b0, NO_RESULT},
		'{CH_SQUOTE, 1'b0, 1'b0, 1'b0, NO_RESULT},
		'{CH_DQUOTE, 1'b0, 1'b0, 1'b0, NO_RESULT},
		'{8'h00,     1'b1, 1'b0, 1'b0, NO_RESULT},
		'{CH_LPAREN, 1'b0, 1'b0, 1'b0, NO_RESULT},
		'{CH_LPAREN, 1'b0, 1'b0, 1'b0, NO_RESULT},
		'{CH_RPAREN, 1'b0, 1'b0, 1'b0, NO_RESULT},
		'{CH_RPAREN, 1'b0, 1'b0, 1'b0, NO_RESULT},
		'{8'h00,     1'b1, 1'b0, 1'b0, NO_RESULT},
		'{8'h00,     1'b1, 1'b1, 1'b1, '{8'h00, 1'b0, STATUS_NOT_FOUND, 1'b1}},
		'{CH_SQUOTE, 1'b0, 1'b0, 1'b0, NO_RESULT},
		'{8'h00,     1'b1, 1'b1, 1'b1, '{8'h00, 1'b0, STATUS_OK, 1'b1}},
		'{"q",       1'b0, 1'b0, 1'b0, NO_RESULT}
	};

	// Clock, and a timeout that ends the run; the single reset pulse is in the main sequence.
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#1_000_000;
		$display("Mismatches found");
		$finish;
	end

	// Predictor helpers.
	function automatic void restart_line();
		mode = MODE_BETWEEN;
		tok_count = 8'd0;
		close_char = 8'd0;
		depth = 8'd0;
		copied = 8'd0;
		line_done = 1'b0;
	endfunction

	function automatic void nest_open();
		if (depth < MAX_NEST)
			depth++;
	endfunction

	function automatic status_t count_copy();
		if (copied != 8'd255)
			copied++;
		return (copied >= len_limit) ? STATUS_TRUNC : STATUS_RUN;
	endfunction

	function automatic result_t emit(input logic [7:0] b, input logic has, input status_t st);
		result_t r;
		r.out_byte = has ? b : 8'h00;
		r.has_byte = has;
		r.status = st;
		r.last = (st != STATUS_RUN);
		if (st != STATUS_RUN)
			line_done = 1'b1;
		return r;
	endfunction

	// Steps the predictor by one character; returns 1 when a token-channel transfer follows.
	function automatic bit scan_char(input logic [7:0] b, input logic e, output result_t r);
		bit ws;
		bit quote;
		status_t st;
		ws = (b == CH_SPACE) || (b == CH_TAB);
		quote = (b == CH_DQUOTE) || (b == CH_SQUOTE);
		r = '0;
		if (e) begin
			if (line_done) begin
				restart_line();
				return 1'b0;
			end
			r = emit(8'h00, 1'b0, (mode inside {MODE_COPY_PLAIN, MODE_COPY_QUOTE,
				MODE_COPY_BRACKET}) ? STATUS_OK : STATUS_NOT_FOUND);
			restart_line();
			return 1'b1;
		end
		if (line_done)
			return 1'b0;
		case (mode)
			MODE_BETWEEN: begin
				if (ws || b == CH_LF || b == CH_CR)
					return 1'b0;
				if (tok_count != 8'd255)
					tok_count++;
				if (want_index != 8'd0 && tok_count == want_index) begin
					if (quote) begin
						close_char = b;
						mode = MODE_COPY_QUOTE;
						return 1'b0;
					end
					if (b == CH_LPAREN) begin
						depth = 8'd1;
						mode = MODE_COPY_BRACKET;
					end else begin
						mode = MODE_COPY_PLAIN;
					end
					r = emit(b, 1'b1, count_copy());
					return 1'b1;
				end
				if (quote) begin
					close_char = b;
					mode = MODE_SKIP_QUOTE;
				end else if (b == CH_LPAREN) begin
					depth = 8'd1;
					mode = MODE_SKIP_BRACKET;
				end else begin
					mode = MODE_SKIP_PLAIN;
				end
				return 1'b0;
			end
			MODE_SKIP_PLAIN: begin
				if (ws)
					mode = MODE_BETWEEN;
				return 1'b0;
			end
			MODE_SKIP_QUOTE: begin
				if (b == close_char)
					mode = MODE_BETWEEN;
				return 1'b0;
			end
			MODE_SKIP_BRACKET: begin
				if (b == CH_RPAREN) begin
					if (depth != 8'd0)
						depth--;
					if (depth == 8'd0)
						mode = MODE_BETWEEN;
				end else if (b == CH_LPAREN) begin
					nest_open();
				end
				return 1'b0;
			end
			MODE_COPY_PLAIN: begin
				r = ws ? emit(8'h00, 1'b0, STATUS_OK) : emit(b, 1'b1, count_copy());
				return 1'b1;
			end
			MODE_COPY_QUOTE: begin
				r = (b == close_char) ? emit(8'h00, 1'b0, STATUS_OK)
					: emit(b, 1'b1, count_copy());
				return 1'b1;
			end
			MODE_COPY_BRACKET: begin
				if (b == CH_RPAREN) begin
					if (depth != 8'd0)
						depth--;
				end else if (b == CH_LPAREN) begin
					nest_open();
				end
				st = count_copy();
				if (st == STATUS_RUN && depth == 8'd0)
					st = STATUS_OK;
				r = emit(b, 1'b1, st);
				return 1'b1;
			end
			default: begin
				mode = MODE_BETWEEN;
				return 1'b0;
			end
		endcase
	endfunction

	function automatic int draw_gap(input bit enabled);
		return enabled ? int'($urandom_range(0, 8)) : 0;
	endfunction

	// Mostly letters, some steering characters, some arbitrary bytes.
	function automatic logic [7:0] pick_byte();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 5)
			return 8'h61 + 8'($urandom_range(0, 25));
		if (sel < 7)
			return SPECIALS[$urandom_range(0, 7)];
		return 8'($urandom_range(0, 255));
	endfunction

	// One character transfer on the input channel, then the predictor step.
	task automatic transfer_char(input logic [7:0] b, input logic e, output bit hit,
		output result_t r);
		int gap;
		gap = draw_gap(send_idle);
		if (gap > 0) begin
			chars_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		chars_bus.valid <= 1'b1;
		chars_bus.in_byte <= b;
		chars_bus.end_of_line <= e;
		do @(posedge clk); while (!chars_bus.ready);
		active_items++;
		hit = scan_char(b, e, r);
	endtask

	// Sends the line held in line_q; a cut line stops halfway with no end of line.
	task automatic send_line(input bit cut);
		int n;
		bit hit;
		result_t r;
		n = cut ? line_q.size() / 2 : line_q.size();
		for (int i = 0; i < n; i++) begin
			transfer_char(line_q[i], 1'b0, hit, r);
			if (hit)
				token_due_q.push_back(r);
		end
		if (!cut) begin
			transfer_char(8'($urandom_range(0, 255)), 1'b1, hit, r);
			if (hit)
				token_due_q.push_back(r);
		end
	endtask

	// Builds a line of plain, quoted and bracketed tokens, or now and then pure noise.
	task automatic build_line();
		int ntok;
		int kind;
		int lvl;
		int seps;
		int sel;
		logic [7:0] c;
		logic [7:0] qc;
		line_q.delete();
		if ($urandom_range(0, 6) == 0) begin
			repeat ($urandom_range(1, 12)) line_q.push_back(pick_byte());
			return;
		end
		if ($urandom_range(0, 2) == 0)
			line_q.push_back(CH_SPACE);
		ntok = $urandom_range(1, 6);
		for (int t = 0; t < ntok; t++) begin
			kind = $urandom_range(0, 2);
			case (kind)
				0: begin
					c = pick_byte();
					if (c inside {CH_SPACE, CH_TAB, CH_LF, CH_CR, CH_DQUOTE, CH_SQUOTE,
						CH_LPAREN})
						c = "p";
					line_q.push_back(c);
					repeat ($urandom_range(0, 5)) begin
						c = pick_byte();
						line_q.push_back((c == CH_SPACE || c == CH_TAB) ? 8'h77 : c);
					end
				end
				1: begin
					qc = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
					line_q.push_back(qc);
					repeat ($urandom_range(0, 6)) begin
						c = pick_byte();
						line_q.push_back((c == qc) ? 8'h6B : c);
					end
					if ($urandom_range(0, 9) != 0)
						line_q.push_back(qc);
				end
				default: begin
					line_q.push_back(CH_LPAREN);
					lvl = 1;
					repeat ($urandom_range(0, 7)) begin
						c = pick_byte();
						if (c == CH_LPAREN) begin
							if (lvl < 4)
								lvl++;
							else
								c = "b";
						end else if (c == CH_RPAREN) begin
							if (lvl > 1)
								lvl--;
							else
								c = "b";
						end
						line_q.push_back(c);
					end
					if ($urandom_range(0, 9) != 0)
						repeat (lvl) line_q.push_back(CH_RPAREN);
				end
			endcase
			// Quote and bracket tokens may be followed directly by the next token.
			seps = (kind != 0 && $urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 2);
			repeat (seps) begin
				sel = $urandom_range(0, 5);
				line_q.push_back(sel < 3 ? CH_SPACE : sel == 3 ? CH_TAB :
					sel == 4 ? CH_LF : CH_CR);
			end
		end
	endtask

	// Stops offering characters and lets every outstanding token transfer drain.
	task automatic wait_idle();
		chars_bus.valid <= 1'b0;
		while (token_due_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input reg_index_t idx, input logic [7:0] val);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
		wr_en <= 1'b0;
		if (idx == REG_TOKEN_INDEX)
			want_index = val;
		else
			len_limit = val;
		@(posedge clk);
	endtask

	// Token-channel receiver: random stalls, and a long hold-off on request.
	initial begin
		int gap;
		tokens_bus.ready <= 1'b0;
		wait (arst_n);
		forever begin
			if (hold_req) begin
				gap = HOLD_CYCLES;
				hold_req = 1'b0;
			end else begin
				gap = draw_gap(recv_idle);
			end
			if (gap > 0) begin
				tokens_bus.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			tokens_bus.ready <= 1'b1;
			do @(posedge clk); while (!tokens_bus.valid);
		end
	end

	function automatic void report_field(input string name, input logic [7:0] want_v,
		input logic [7:0] got_v);
		mismatch_count++;
		$display("%0t ns: %s expected %0h, got %0h", $time, name, want_v, got_v);
	endfunction

	// Compare each token transfer with the oldest prediction.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && tokens_bus.valid && tokens_bus.ready) begin
			if (token_due_q.size() == 0) begin
				mismatch_count++;
				$display("%0t ns: unexpected transfer, expected none, got %0h", $time,
					{tokens_bus.out_byte, tokens_bus.has_byte, tokens_bus.status,
					tokens_bus.last});
			end else begin
				want = token_due_q.pop_front();
				if (tokens_bus.out_byte !== want.out_byte)
					report_field("out_byte", want.out_byte, tokens_bus.out_byte);
				if (tokens_bus.has_byte !== want.has_byte)
					report_field("has_byte", want.has_byte, tokens_bus.has_byte);
				if (tokens_bus.status !== want.status)
					report_field("status", want.status, tokens_bus.status);
				if (tokens_bus.last !== want.last)
					report_field("last", want.last, tokens_bus.last);
			end
		end
	end

	// Main sequence: reset, directed table, then randomized phases.
	initial begin
		bit hit;
		result_t r;
		int phase;
		int n_lines;
		logic [7:0] idx_val;
		logic [7:0] len_val;
		arst_n = 1'b0;
		chars_bus.valid <= 1'b0;
		chars_bus.in_byte <= 8'h00;
		chars_bus.end_of_line <= 1'b0;
		wr_en <= 1'b0;
		wr_index <= REG_TOKEN_INDEX;
		wr_data <= 8'h00;
		want_index = 8'd1;
		len_limit = 8'd64;
		restart_line();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_table[i]) begin
			transfer_char(dir_table[i].ch, dir_table[i].eol, hit, r);
			if (dir_table[i].typed) begin
				if (dir_table[i].has_res)
					token_due_q.push_back(dir_table[i].res);
			end else if (hit) begin
				token_due_q.push_back(r);
			end
		end

		phase = 0;
		active_items = 0;
		while (active_items < RANDOM_ITEMS) begin
			// Extremes first, then a deep nesting line, then random settings.
			case (phase)
				0: begin idx_val = 8'd1;   len_val = 8'd1;   end
				1: begin idx_val = 8'd255; len_val = 8'd255; end
				2: begin idx_val = 8'd2;   len_val = 8'd255; end
				default: begin
					idx_val = ($urandom_range(0, 9) < 8) ? 8'($urandom_range(1, 4))
						: 8'($urandom_range(1, 255));
					len_val = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(1, 4))
						: ($urandom_range(0, 9) == 0) ? 8'd255 : 8'($urandom_range(5, 64));
				end
			endcase
			wait_idle();
			write_reg(REG_TOKEN_INDEX, idx_val);
			write_reg(REG_MAX_LEN, len_val);
			send_idle = ($urandom_range(0, 3) != 0);
			recv_idle = ($urandom_range(0, 3) != 0);
			if (phase % 7 == 3) begin
				hold_req = 1'b1;
				send_idle = 1'b0;
			end
			if (phase == 2) begin
				// Nesting beyond the counter limit; the surplus closers become the next token.
				line_q.delete();
				repeat (256) line_q.push_back(CH_LPAREN);
				repeat (257) line_q.push_back(CH_RPAREN);
				line_q.push_back("z");
				send_line(1'b0);
			end else begin
				n_lines = $urandom_range(2, 5);
				for (int l = 0; l < n_lines; l++) begin
					build_line();
					send_line(l == n_lines - 1 && $urandom_range(0, 3) == 0);
				end
			end
			phase++;
		end

		chars_bus.valid <= 1'b0;
		while (token_due_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
